>>> hdl/bdpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce / press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ID_W = 3;
  localparam int STAMP_W = 32;
  localparam int MS_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd2;

  // Input item kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Reset values of the registers
  localparam logic ENABLE_RST = 1'b1;
  localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [MS_W-1:0] LONG_PRESS_RST = 16'd2000;

  typedef struct packed {
    logic            enable;
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]    pressed_button;
    logic               long_press;
    logic [STAMP_W-1:0] hold_ms;
  } event_t;

endpackage

>>> hdl/button_debounce_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces timestamped button edges and reports each completed press with
// its hold time and a long-press flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per button edge (kind=0) or per "done" ack
//           (kind=1) from whoever consumed the last press event. Taken when
//           in_valid is high and in_stall is low.
//   out_* : one transaction per recognized release (button, hold, long flag).
//           Taken when out_valid is high and out_stall is low.
//   cfg_* : register writes (0 enable, 1 debounce_ms, 2 long_press_ms);
//           cfg_ready is always high. Write only while the block is idle.
// Flow: an accepted item is held in the input register and qualified out of
//   it when the output register can take a result; its result then enters
//   the output register, while an item that makes no result just retires.
// Throughput: one item per cycle while out_stall does not hold the output
//   register, bounded by the single stage between input and result register.
// Reset (rst_n low, synchronous): all buttons idle, stamps zero, nothing
//   pending, registers back to enable=1, debounce 20 ms, long press 2000 ms.
// Stall: while out_stall holds a result in the output register, the item in
//   the input register waits (in_stall high), even one that makes no result;
//   an empty input register still takes one more transaction.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier #(
  parameter int NUM_BUTTONS = 5,
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [bdpc_pkg::ID_W-1:0]       in_button_id,
  input  logic [bdpc_pkg::STAMP_W-1:0]    in_timestamp_ms,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bdpc_pkg::ID_W-1:0]       out_pressed_button,
  output logic                            out_long_press,
  output logic [bdpc_pkg::STAMP_W-1:0]    out_hold_ms,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bdpc_pkg::cfg_t cfg;

  // Input register
  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_kind_r;
  logic [bdpc_pkg::ID_W-1:0]    s1_id_r;
  logic [bdpc_pkg::STAMP_W-1:0] s1_ts_r;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  bdpc_pkg::event_t   out_ev_r;

  logic             advance;   // stage 2 may retire the held item
  logic             step;
  logic             in_take;
  logic             ev_valid;
  bdpc_pkg::event_t ev;

  assign cfg_ready = 1'b1;

  bdpc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // Output slot is free, or is being emptied this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  bdpc_core #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .kind         (s1_kind_r),
    .button_id    (s1_id_r),
    .timestamp_ms (s1_ts_r),
    .cfg          (cfg),
    .ev_valid     (ev_valid),
    .ev           (ev)
  );

  always_comb begin
    s1_valid_nxt = in_take || (s1_valid_r && !step);
    out_valid_nxt = out_valid_r;
    if (step && ev_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r <= in_kind;
      s1_id_r   <= in_button_id;
      s1_ts_r   <= in_timestamp_ms;
    end
    if (step && ev_valid) begin
      out_ev_r <= ev;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pressed_button = out_ev_r.pressed_button;
  assign out_long_press     = out_ev_r.long_press;
  assign out_hold_ms        = out_ev_r.hold_ms;

endmodule

>>> hdl/bdpc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_cfg
// Configuration register file: enable, debounce time, long-press limit.
// ----------------------------------------------------------------------------
module bdpc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [bdpc_pkg::CFG_DATA_W-1:0]  wr_data,
  output bdpc_pkg::cfg_t                   cfg
);

  bdpc_pkg::cfg_t cfg_r;
  bdpc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        bdpc_pkg::REG_ENABLE:     cfg_nxt.enable = wr_data[0];
        bdpc_pkg::REG_DEBOUNCE:   cfg_nxt.debounce_ms = wr_data;
        bdpc_pkg::REG_LONG_PRESS: cfg_nxt.long_press_ms = wr_data;
        default:                  cfg_nxt = cfg_r;  // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= bdpc_pkg::ENABLE_RST;
      cfg_r.debounce_ms <= bdpc_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ms <= bdpc_pkg::LONG_PRESS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/bdpc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_core
// Per-button press/release state and stamps; qualifies one item per step.
// ----------------------------------------------------------------------------
module bdpc_core #(
  parameter int NUM_BUTTONS = 5,
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic                            kind,
  input  logic [bdpc_pkg::ID_W-1:0]       button_id,
  input  logic [bdpc_pkg::STAMP_W-1:0]    timestamp_ms,
  input  bdpc_pkg::cfg_t                  cfg,
  output logic                            ev_valid,
  output bdpc_pkg::event_t                ev
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [NUM_BUTTONS-1:0] held_r, held_nxt;
  logic [TIME_BITS-1:0]   press_stamp_r [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   release_stamp_r [NUM_BUTTONS];
  logic                   pending_r, pending_nxt;

  logic [31:0]                          id_ext;
  logic [IDX_W-1:0]                     idx;
  logic                                 id_ok;
  logic [TIME_BITS+bdpc_pkg::STAMP_W-1:0] now_ext;
  logic [TIME_BITS-1:0]                 now;
  logic [TIME_BITS+bdpc_pkg::MS_W-1:0]  deb_ext, lp_ext;
  logic [TIME_BITS-1:0]                 deb, lp;
  logic [TIME_BITS-1:0]                 since_rel, hold;
  logic [TIME_BITS+bdpc_pkg::STAMP_W-1:0] hold_ext;
  logic                                 edge_ok;
  logic                                 do_press, do_release;

  always_comb begin
    id_ext  = {{(32-bdpc_pkg::ID_W){1'b0}}, button_id};
    idx     = id_ext[IDX_W-1:0];
    id_ok   = (id_ext < NUM_BUTTONS);
    now_ext = {{TIME_BITS{1'b0}}, timestamp_ms};
    now     = now_ext[TIME_BITS-1:0];
    deb_ext = {{TIME_BITS{1'b0}}, cfg.debounce_ms};
    deb     = deb_ext[TIME_BITS-1:0];
    lp_ext  = {{TIME_BITS{1'b0}}, cfg.long_press_ms};
    lp      = lp_ext[TIME_BITS-1:0];

    since_rel = '0;
    hold      = '0;
    if (id_ok) begin
      since_rel = now - release_stamp_r[idx];
      hold      = now - press_stamp_r[idx];
    end
    hold_ext = {{bdpc_pkg::STAMP_W{1'b0}}, hold};

    edge_ok    = step && (kind == bdpc_pkg::KIND_EDGE) && !pending_r && cfg.enable && id_ok;
    do_press   = edge_ok && !held_r[idx] && (since_rel > deb);
    do_release = edge_ok && held_r[idx] && (hold > deb);

    held_nxt    = held_r;
    pending_nxt = pending_r;
    if (step && (kind == bdpc_pkg::KIND_DONE)) begin
      pending_nxt = 1'b0;
    end
    if (do_press) begin
      held_nxt[idx] = 1'b1;
    end
    if (do_release) begin
      held_nxt    = '0;   // release returns every button to idle
      pending_nxt = 1'b1;
    end

    ev_valid          = do_release;
    ev.pressed_button = button_id;
    ev.long_press     = (hold >= lp);
    ev.hold_ms        = hold_ext[bdpc_pkg::STAMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      pending_r <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_stamp_r[i]   <= '0;
        release_stamp_r[i] <= '0;
      end
    end else begin
      held_r    <= held_nxt;
      pending_r <= pending_nxt;
      if (do_press) begin
        press_stamp_r[idx] <= now;
      end
      if (do_release) begin
        release_stamp_r[idx] <= now;
      end
    end
  end

endmodule
